// ===== sv/vrc_pkg.sv =====
// Shared types and constants for the scaled rectangle clip block.
// Used by vrc_trim, vrc_axis and the top level; depends on nothing else.
package vrc_pkg;

  localparam int SIZE_BITS   = 15;
  localparam int PROD_BITS   = 2 * SIZE_BITS;
  localparam int DIV_STEPS   = SIZE_BITS;
  // Trim step: trim/own update, multiply, range check, divide steps, carry.
  localparam int TRIM_STAGES = DIV_STEPS + 4;
  // Axis lane: entry stage plus four trim steps.
  localparam int AXIS_STAGES = 1 + 4 * TRIM_STAGES;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [1:0]           cfg_idx_t;

  localparam size_t SIZE_MAX = '1;

  localparam cfg_idx_t CFG_MAX_SRC_W = 2'd0;
  localparam cfg_idx_t CFG_MAX_SRC_H = 2'd1;
  localparam cfg_idx_t CFG_MAX_DST_W = 2'd2;
  localparam cfg_idx_t CFG_MAX_DST_H = 2'd3;

  // Per-axis working state that travels down a lane.
  typedef struct packed {
    logic                 ok;     // no size has dropped to zero or below
    logic                 clip;   // some trim was applied
    logic                 scale;  // sizes differed at axis start
    logic                 fix_s;
    logic                 fix_d;
    logic                 act;    // current trim step is active
    logic                 sat;    // quotient is at least 2**SIZE_BITS
    size_t                sw;
    size_t                dw;
    size_t                osz;
    size_t                odz;
    size_t                t;
    size_t                q;
    logic [PROD_BITS-1:0] rem;
  } vrc_ctl_t;

endpackage

// ===== sv/video_rect_clip_and_scale.sv =====
// Scaled source/destination rectangle clip, top level.
// Uses vrc_pkg, vrc_axis, vrc_delay.
//
// Input words arrive on the s_ channel, one clip request per word; results
// leave on the m_ channel, one word per request, in request order. The
// four maximum extents are written through cfg_we/cfg_index/cfg_data and
// should only change while no request is in flight.
// The x and y axes run in two parallel lanes. Each lane has an entry stage
// and four trim steps of 19 stages each; the carry of every trim goes
// through a 15-step restoring divider, one quotient bit per stage. Each
// request passes the 77 lane stages, its result then the output register;
// a new request is taken every cycle while the output buffer is not full.
// A two-word output buffer sits at the end: s_tready depends only on
// whether that buffer is full, so a request is still taken while one
// result waits. When the receiver holds m_tready low, the whole pipeline
// freezes once the buffer fills and resumes without loss when it drains.
// Synchronous reset empties the pipeline and the buffer and sets all four
// maximum extents to 32767.
module video_rect_clip_and_scale #(
  parameter int COORD_BITS = 16
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       s_tvalid,
  output logic                                       s_tready,
  // src_x, src_y, src_w, src_h, dst_x, dst_y, dst_w, dst_h,
  // orig_src_w, orig_src_h, orig_dst_w, orig_dst_h
  input  logic [((4*COORD_BITS+120+7)/8)*8-1:0]      s_tdata,
  output logic                                       m_tvalid,
  input  logic                                       m_tready,
  // out_src_x, out_src_y, out_src_w, out_src_h, out_dst_x, out_dst_y,
  // out_dst_w, out_dst_h, clipped, work_to_do
  output logic [((4*COORD_BITS+62+7)/8)*8-1:0]       m_tdata,
  input  logic                                       cfg_we,
  input  vrc_pkg::cfg_idx_t                          cfg_index,
  input  vrc_pkg::size_t                             cfg_data
);
  import vrc_pkg::*;

  localparam int W        = COORD_BITS;
  localparam int O_SY     = W;
  localparam int O_SW     = 2*W;
  localparam int O_SH     = 2*W + 15;
  localparam int O_DX     = 2*W + 30;
  localparam int O_DY     = 3*W + 30;
  localparam int O_DW     = 4*W + 30;
  localparam int O_DH     = 4*W + 45;
  localparam int O_OSW    = 4*W + 60;
  localparam int O_OSH    = 4*W + 75;
  localparam int O_ODW    = 4*W + 90;
  localparam int O_ODH    = 4*W + 105;
  localparam int RECT_BITS = 4*W + 60;
  localparam int O_CLIP   = 4*W + 60;
  localparam int O_WTD    = 4*W + 61;
  localparam int OUT_W    = ((4*W + 62 + 7) / 8) * 8;

  // Configuration registers.
  size_t max_src_w, max_src_h, max_dst_w, max_dst_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_src_w <= SIZE_MAX;
      max_src_h <= SIZE_MAX;
      max_dst_w <= SIZE_MAX;
      max_dst_h <= SIZE_MAX;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_SRC_W: max_src_w <= cfg_data;
        CFG_MAX_SRC_H: max_src_h <= cfg_data;
        CFG_MAX_DST_W: max_dst_w <= cfg_data;
        CFG_MAX_DST_H: max_dst_h <= cfg_data;
      endcase
    end
  end

  logic ce;
  logic in_acc;
  logic skid_valid;
  logic out_valid;

  assign ce       = !skid_valid;
  assign s_tready = ce;
  assign in_acc   = s_tvalid && ce;

  logic         x_valid, y_valid;
  logic [W-1:0] x_sp, x_dp, y_sp, y_dp;
  size_t        x_sw, x_dw, y_sw, y_dw;
  logic         x_clip, y_clip, x_ok, y_ok;

  vrc_axis #(.COORD_BITS(W)) u_axis_x (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (in_acc),
    .in_sp     (s_tdata[W-1:0]),
    .in_sw     (s_tdata[O_SW+14:O_SW]),
    .in_dp     (s_tdata[O_DX+W-1:O_DX]),
    .in_dw     (s_tdata[O_DW+14:O_DW]),
    .in_osz    (s_tdata[O_OSW+14:O_OSW]),
    .in_odz    (s_tdata[O_ODW+14:O_ODW]),
    .smax      (max_src_w),
    .dmax      (max_dst_w),
    .out_valid (x_valid),
    .out_sp    (x_sp),
    .out_sw    (x_sw),
    .out_dp    (x_dp),
    .out_dw    (x_dw),
    .out_clip  (x_clip),
    .out_ok    (x_ok)
  );

  vrc_axis #(.COORD_BITS(W)) u_axis_y (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (in_acc),
    .in_sp     (s_tdata[O_SY+W-1:O_SY]),
    .in_sw     (s_tdata[O_SH+14:O_SH]),
    .in_dp     (s_tdata[O_DY+W-1:O_DY]),
    .in_dw     (s_tdata[O_DH+14:O_DH]),
    .in_osz    (s_tdata[O_OSH+14:O_OSH]),
    .in_odz    (s_tdata[O_ODH+14:O_ODH]),
    .smax      (max_src_h),
    .dmax      (max_dst_h),
    .out_valid (y_valid),
    .out_sp    (y_sp),
    .out_sw    (y_sw),
    .out_dp    (y_dp),
    .out_dw    (y_dw),
    .out_clip  (y_clip),
    .out_ok    (y_ok)
  );

  // The input rectangles ride alongside for the empty-result case.
  logic [RECT_BITS-1:0] orig_rect;

  vrc_delay #(.WIDTH(RECT_BITS), .DEPTH(AXIS_STAGES)) u_orig (
    .clk  (clk),
    .ce   (ce),
    .din  (s_tdata[RECT_BITS-1:0]),
    .dout (orig_rect)
  );

  logic             pipe_valid;
  logic             push;
  logic             pop;
  logic [OUT_W-1:0] res;

  assign pipe_valid = x_valid && y_valid;
  assign push       = ce && pipe_valid;
  assign pop        = out_valid && m_tready;

  always_comb begin
    res = '0;
    if (x_ok && y_ok) begin
      res[W-1:0]          = x_sp;
      res[O_SY+W-1:O_SY]  = y_sp;
      res[O_SW+14:O_SW]   = x_sw;
      res[O_SH+14:O_SH]   = y_sw;
      res[O_DX+W-1:O_DX]  = x_dp;
      res[O_DY+W-1:O_DY]  = y_dp;
      res[O_DW+14:O_DW]   = x_dw;
      res[O_DH+14:O_DH]   = y_dw;
      res[O_CLIP]         = x_clip || y_clip;
      res[O_WTD]          = 1'b1;
    end else begin
      res[RECT_BITS-1:0]  = orig_rect;
      res[O_CLIP]         = 1'b1;
    end
  end

  // Two-word output buffer: the head drives the port, the skid word
  // catches a result that arrives while the head is stalled.
  logic [OUT_W-1:0] out_data;
  logic [OUT_W-1:0] skid_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= res;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data <= res;
      end else begin
        out_data <= res;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

// ===== sv/vrc_delay.sv =====
// Enabled shift line that carries a word alongside the axis lanes.
// Generic; no package dependency.
module vrc_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             ce,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (ce) begin
      line[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

// ===== sv/vrc_trim.sv =====
// One trim step of an axis lane: trim the own rectangle, then carry the
// trim to the partner through a pipelined restoring divider. Uses vrc_pkg.
module vrc_trim #(
  parameter int PW       = 18,
  parameter bit DST_SIDE = 1'b0,
  parameter bit AT_END   = 1'b0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ce,
  input  logic               in_valid,
  input  vrc_pkg::vrc_ctl_t  in_ctl,
  input  logic signed [PW-1:0] in_sp,
  input  logic signed [PW-1:0] in_dp,
  input  vrc_pkg::size_t     own_max,
  output logic               out_valid,
  output vrc_pkg::vrc_ctl_t  out_ctl,
  output logic signed [PW-1:0] out_sp,
  output logic signed [PW-1:0] out_dp
);
  import vrc_pkg::*;

  localparam int TW  = PW + 2;
  localparam int NST = TRIM_STAGES;

  function automatic size_t num_of(vrc_ctl_t c);
    return DST_SIDE ? c.osz : c.odz;
  endfunction

  function automatic size_t den_of(vrc_ctl_t c);
    return DST_SIDE ? c.odz : c.osz;
  endfunction

  logic [NST-1:0]     vld;
  vrc_ctl_t           ctl      [NST];
  vrc_ctl_t           ctl_next [NST];
  logic signed [PW-1:0] sp      [NST];
  logic signed [PW-1:0] sp_next [NST];
  logic signed [PW-1:0] dp      [NST];
  logic signed [PW-1:0] dp_next [NST];

  // Trim stage: find the trim and apply it to the own rectangle.
  logic signed [TW-1:0] own_pos;
  logic signed [TW-1:0] trim;
  logic signed [TW-1:0] own_rem;
  size_t                own_size;
  logic                 own_fix;
  vrc_ctl_t             a_ctl;
  logic signed [PW-1:0] a_sp;
  logic signed [PW-1:0] a_dp;

  always_comb begin
    own_pos  = DST_SIDE ? {{2{in_dp[PW-1]}}, in_dp} : {{2{in_sp[PW-1]}}, in_sp};
    own_size = DST_SIDE ? in_ctl.dw : in_ctl.sw;
    own_fix  = DST_SIDE ? in_ctl.fix_d : in_ctl.fix_s;
    if (AT_END) begin
      trim = own_pos + $signed({{(TW-SIZE_BITS){1'b0}}, own_size})
             - $signed({{(TW-SIZE_BITS){1'b0}}, own_max});
    end else begin
      trim = -own_pos;
    end
    own_rem   = $signed({{(TW-SIZE_BITS){1'b0}}, own_size}) - trim;
    a_ctl     = in_ctl;
    a_sp      = in_sp;
    a_dp      = in_dp;
    a_ctl.act = in_ctl.ok && own_fix && (trim > 0);
    a_ctl.t   = trim[SIZE_BITS-1:0];
    a_ctl.sat = 1'b0;
    a_ctl.q   = '0;
    a_ctl.rem = '0;
    if (a_ctl.act) begin
      a_ctl.clip = 1'b1;
      if (own_rem <= 0) begin
        a_ctl.ok = 1'b0;
      end
      if (DST_SIDE) begin
        a_ctl.dw = own_rem[SIZE_BITS-1:0];
        if (!AT_END) begin
          a_dp = '0;
        end
      end else begin
        a_ctl.sw = own_rem[SIZE_BITS-1:0];
        if (!AT_END) begin
          a_sp = '0;
        end
      end
    end
  end

  assign ctl_next[0] = a_ctl;
  assign sp_next[0]  = a_sp;
  assign dp_next[0]  = a_dp;

  // Multiply stage: the trim is below 2**15 whenever the carry matters.
  vrc_ctl_t m_ctl;
  always_comb begin
    m_ctl     = ctl[0];
    m_ctl.rem = PROD_BITS'(ctl[0].t) * PROD_BITS'(num_of(ctl[0]));
  end
  assign ctl_next[1] = m_ctl;
  assign sp_next[1]  = sp[0];
  assign dp_next[1]  = dp[0];

  // Range stage: a quotient of 2**15 or more empties the partner anyway.
  vrc_ctl_t s_ctl;
  always_comb begin
    s_ctl     = ctl[1];
    s_ctl.sat = (ctl[1].rem[PROD_BITS-1:SIZE_BITS] >= den_of(ctl[1]));
  end
  assign ctl_next[2] = s_ctl;
  assign sp_next[2]  = sp[1];
  assign dp_next[2]  = dp[1];

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int BIT = DIV_STEPS - 1 - k;
    vrc_ctl_t             d_ctl;
    logic [PROD_BITS-1:0] part;
    always_comb begin
      d_ctl = ctl[2+k];
      part  = PROD_BITS'(den_of(ctl[2+k])) << BIT;
      if (ctl[2+k].rem >= part) begin
        d_ctl.rem    = ctl[2+k].rem - part;
        d_ctl.q[BIT] = 1'b1;
      end
    end
    assign ctl_next[3+k] = d_ctl;
    assign sp_next[3+k]  = sp[2+k];
    assign dp_next[3+k]  = dp[2+k];
  end

  // Carry stage: apply the scaled trim to the partner rectangle.
  vrc_ctl_t                c_ctl;
  logic [SIZE_BITS:0]      carry;
  logic signed [SIZE_BITS+1:0] p_rem;
  logic signed [PW-1:0]    c_sp;
  logic signed [PW-1:0]    c_dp;

  always_comb begin
    c_ctl = ctl[NST-2];
    c_sp  = sp[NST-2];
    c_dp  = dp[NST-2];
    if (!c_ctl.scale || (den_of(c_ctl) == '0)) begin
      carry = {1'b0, c_ctl.t};
    end else if (c_ctl.sat) begin
      carry = {1'b1, {SIZE_BITS{1'b0}}};
    end else begin
      carry = {1'b0, c_ctl.q};
    end
    p_rem = $signed({2'b00, (DST_SIDE ? c_ctl.sw : c_ctl.dw)}) - $signed({1'b0, carry});
    if (c_ctl.act && c_ctl.ok) begin
      if (p_rem <= 0) begin
        c_ctl.ok = 1'b0;
      end
      if (DST_SIDE) begin
        c_ctl.sw = p_rem[SIZE_BITS-1:0];
        if (!AT_END) begin
          c_sp = sp[NST-2] + $signed({{(PW-SIZE_BITS-1){1'b0}}, carry});
        end
      end else begin
        c_ctl.dw = p_rem[SIZE_BITS-1:0];
        if (!AT_END) begin
          c_dp = dp[NST-2] + $signed({{(PW-SIZE_BITS-1){1'b0}}, carry});
        end
      end
    end
  end
  assign ctl_next[NST-1] = c_ctl;
  assign sp_next[NST-1]  = c_sp;
  assign dp_next[NST-1]  = c_dp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ce) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < NST; i++) begin
        ctl[i] <= ctl_next[i];
        sp[i]  <= sp_next[i];
        dp[i]  <= dp_next[i];
      end
    end
  end

  assign out_valid = vld[NST-1];
  assign out_ctl   = ctl[NST-1];
  assign out_sp    = sp[NST-1];
  assign out_dp    = dp[NST-1];

endmodule

// ===== sv/vrc_axis.sv =====
// One axis lane: entry stage with fix flags, then source start, source end,
// destination start and destination end trims. Uses vrc_pkg and vrc_trim.
module vrc_axis #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic signed [COORD_BITS-1:0] in_sp,
  input  vrc_pkg::size_t               in_sw,
  input  logic signed [COORD_BITS-1:0] in_dp,
  input  vrc_pkg::size_t               in_dw,
  input  vrc_pkg::size_t               in_osz,
  input  vrc_pkg::size_t               in_odz,
  input  vrc_pkg::size_t               smax,
  input  vrc_pkg::size_t               dmax,
  output logic                         out_valid,
  output logic [COORD_BITS-1:0]        out_sp,
  output vrc_pkg::size_t               out_sw,
  output logic [COORD_BITS-1:0]        out_dp,
  output vrc_pkg::size_t               out_dw,
  output logic                         out_clip,
  output logic                         out_ok
);
  import vrc_pkg::*;

  localparam int PW = (COORD_BITS > 16 ? COORD_BITS : 16) + 2;

  logic signed [PW-1:0] sp_ext;
  logic signed [PW-1:0] dp_ext;
  logic signed [PW-1:0] s_end;
  logic signed [PW-1:0] d_end;
  vrc_ctl_t             e_ctl;

  always_comb begin
    sp_ext      = {{(PW-COORD_BITS){in_sp[COORD_BITS-1]}}, in_sp};
    dp_ext      = {{(PW-COORD_BITS){in_dp[COORD_BITS-1]}}, in_dp};
    s_end       = sp_ext + $signed({{(PW-SIZE_BITS){1'b0}}, in_sw});
    d_end       = dp_ext + $signed({{(PW-SIZE_BITS){1'b0}}, in_dw});
    e_ctl       = '0;
    e_ctl.ok    = 1'b1;
    e_ctl.scale = (in_dw != in_sw);
    e_ctl.fix_s = (sp_ext < 0) || (s_end > $signed({{(PW-SIZE_BITS){1'b0}}, smax}));
    e_ctl.fix_d = (dp_ext < 0) || (d_end > $signed({{(PW-SIZE_BITS){1'b0}}, dmax}));
    e_ctl.sw    = in_sw;
    e_ctl.dw    = in_dw;
    e_ctl.osz   = in_osz;
    e_ctl.odz   = in_odz;
  end

  logic                 lv  [5];
  vrc_ctl_t             lc  [5];
  logic signed [PW-1:0] lsp [5];
  logic signed [PW-1:0] ldp [5];

  always_ff @(posedge clk) begin
    if (rst) begin
      lv[0] <= 1'b0;
    end else if (ce) begin
      lv[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      lc[0]  <= e_ctl;
      lsp[0] <= sp_ext;
      ldp[0] <= dp_ext;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_step
    vrc_trim #(
      .PW       (PW),
      .DST_SIDE (k >= 2),
      .AT_END   ((k % 2) == 1)
    ) u_trim (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .in_valid  (lv[k]),
      .in_ctl    (lc[k]),
      .in_sp     (lsp[k]),
      .in_dp     (ldp[k]),
      .own_max   ((k >= 2) ? dmax : smax),
      .out_valid (lv[k+1]),
      .out_ctl   (lc[k+1]),
      .out_sp    (lsp[k+1]),
      .out_dp    (ldp[k+1])
    );
  end

  assign out_valid = lv[4];
  assign out_sp    = lsp[4][COORD_BITS-1:0];
  assign out_dp    = ldp[4][COORD_BITS-1:0];
  assign out_sw    = lc[4].sw;
  assign out_dw    = lc[4].dw;
  assign out_clip  = lc[4].clip;
  assign out_ok    = lc[4].ok;

endmodule

// ===== sv/vrc_checker.sv =====
// Port-level checks for the rectangle clip top level, attached by bind.
// Depends only on the top level's ports.
module vrc_checker #(
  parameter int COORD_BITS = 16
) (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [((4*COORD_BITS+62+7)/8)*8-1:0]  m_tdata
);

  localparam int O_CLIP = 4*COORD_BITS + 60;
  localparam int O_WTD  = 4*COORD_BITS + 61;

  // A stalled result word stays put.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // An empty result is always reported as clipped.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[O_CLIP] || m_tdata[O_WTD])
    else $error("empty result without clipped flag");

  // The buffer can only be full while a result is shown.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  a_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready && !(m_tvalid && m_tready) |=> !s_tready)
    else $error("input released without a result taken");

endmodule

bind video_rect_clip_and_scale vrc_checker #(.COORD_BITS(COORD_BITS)) u_vrc_checker (.*);

// ===== test/vrc_clip_checker.sv =====
// Checker for the scaled rectangle clip block: watches the request, result and
// register write ports, predicts each result and compares. Depends on vrc_pkg.
module vrc_clip_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [183:0]      s_tdata,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [127:0]      m_tdata,
  input  logic              cfg_we,
  input  vrc_pkg::cfg_idx_t cfg_index,
  input  vrc_pkg::size_t    cfg_data,
  output int                errors,
  output int                pending
);
  import vrc_pkg::*;

  typedef struct packed {
    logic        wtd;
    logic        clipped;
    size_t       dh;
    size_t       dw;
    logic [15:0] dy;
    logic [15:0] dx;
    size_t       sh;
    size_t       sw;
    logic [15:0] sy;
    logic [15:0] sx;
  } clip_res_t;

  size_t lim_sw, lim_sh, lim_dw, lim_dh;
  clip_res_t clip_q[$];

  function automatic longint carried(longint t, bit scale, longint num, longint den);
    if (!scale || den == 0) return t;
    return (t * num) / den;
  endfunction

  // Trims one axis in place; returns 0 once a size falls to zero or below.
  function automatic bit trim_axis(bit fs, bit fd, inout longint sp, inout longint sw,
                                   inout longint dp, inout longint dw, input longint smax,
                                   input longint dmax, input longint osz, input longint odz,
                                   inout bit clip);
    bit scale;
    longint t;
    scale = (dw != sw);
    if (fs) begin
      if (sp < 0) begin
        t = -sp; clip = 1; sp += t; sw -= t;
        if (sw <= 0) return 0;
        t = carried(t, scale, odz, osz); dp += t; dw -= t;
        if (dw <= 0) return 0;
      end
      t = sp + sw - smax;
      if (t > 0) begin
        clip = 1; sw -= t;
        if (sw <= 0) return 0;
        dw -= carried(t, scale, odz, osz);
        if (dw <= 0) return 0;
      end
    end
    if (fd) begin
      if (dp < 0) begin
        t = -dp; clip = 1; dp += t; dw -= t;
        if (dw <= 0) return 0;
        t = carried(t, scale, osz, odz); sp += t; sw -= t;
        if (sw <= 0) return 0;
      end
      t = dp + dw - dmax;
      if (t > 0) begin
        clip = 1; dw -= t;
        if (dw <= 0) return 0;
        sw -= carried(t, scale, osz, odz);
        if (sw <= 0) return 0;
      end
    end
    return 1;
  endfunction

  function automatic clip_res_t predict_clip(logic [183:0] d);
    longint sx, sy, sw, sh, dx, dy, dw, dh, osw, osh, odw, odh;
    longint rsx, rsy, rsw, rsh, rdx, rdy, rdw, rdh;
    bit fsx, fdx, fsy, fdy, clip, ok;
    clip_res_t r;
    sx = longint'($signed(d[15:0]));   sy = longint'($signed(d[31:16]));
    sw = d[46:32];                      sh = d[61:47];
    dx = longint'($signed(d[77:62]));  dy = longint'($signed(d[93:78]));
    dw = d[108:94];                     dh = d[123:109];
    osw = d[138:124]; osh = d[153:139]; odw = d[168:154]; odh = d[183:169];
    fsx = sx < 0 || sx + sw > lim_sw;
    fdx = dx < 0 || dx + dw > lim_dw;
    fsy = sy < 0 || sy + sh > lim_sh;
    fdy = dy < 0 || dy + dh > lim_dh;
    rsx = sx; rsy = sy; rsw = sw; rsh = sh; rdx = dx; rdy = dy; rdw = dw; rdh = dh;
    clip = 0;
    ok = 1;
    if (fsx || fdx)
      ok = trim_axis(fsx, fdx, rsx, rsw, rdx, rdw, lim_sw, lim_dw, osw, odw, clip);
    if (ok && (fsy || fdy))
      ok = trim_axis(fsy, fdy, rsy, rsh, rdy, rdh, lim_sh, lim_dh, osh, odh, clip);
    if (!ok) begin
      rsx = sx; rsy = sy; rsw = sw; rsh = sh; rdx = dx; rdy = dy; rdw = dw; rdh = dh;
      clip = 1;
    end
    r.sx = rsx[15:0]; r.sy = rsy[15:0]; r.sw = rsw[14:0]; r.sh = rsh[14:0];
    r.dx = rdx[15:0]; r.dy = rdy[15:0]; r.dw = rdw[14:0]; r.dh = rdh[14:0];
    r.clipped = clip;
    r.wtd = ok;
    return r;
  endfunction

  always @(posedge clk) begin
    clip_res_t want, got;
    if (rst) begin
      lim_sw <= SIZE_MAX; lim_sh <= SIZE_MAX; lim_dw <= SIZE_MAX; lim_dh <= SIZE_MAX;
      clip_q.delete();
      errors <= 0;
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_SRC_W: lim_sw <= cfg_data;
          CFG_MAX_SRC_H: lim_sh <= cfg_data;
          CFG_MAX_DST_W: lim_dw <= cfg_data;
          CFG_MAX_DST_H: lim_dh <= cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) clip_q.push_back(predict_clip(s_tdata));
      if (m_tvalid && m_tready) begin
        got = clip_res_t'(m_tdata[125:0]);
        if (clip_q.size() == 0) begin
          $error("result word with no request outstanding: %h", m_tdata);
          errors <= errors + 1;
        end else begin
          want = clip_q.pop_front();
          if (got != want) begin
            errors <= errors + 1;
            if (got.sx != want.sx)
              $error("out_src_x exp %0d got %0d", $signed(want.sx), $signed(got.sx));
            if (got.sy != want.sy)
              $error("out_src_y exp %0d got %0d", $signed(want.sy), $signed(got.sy));
            if (got.sw != want.sw) $error("out_src_w exp %0d got %0d", want.sw, got.sw);
            if (got.sh != want.sh) $error("out_src_h exp %0d got %0d", want.sh, got.sh);
            if (got.dx != want.dx)
              $error("out_dst_x exp %0d got %0d", $signed(want.dx), $signed(got.dx));
            if (got.dy != want.dy)
              $error("out_dst_y exp %0d got %0d", $signed(want.dy), $signed(got.dy));
            if (got.dw != want.dw) $error("out_dst_w exp %0d got %0d", want.dw, got.dw);
            if (got.dh != want.dh) $error("out_dst_h exp %0d got %0d", want.dh, got.dh);
            if (got.clipped != want.clipped)
              $error("clipped exp %0d got %0d", want.clipped, got.clipped);
            if (got.wtd != want.wtd)
              $error("work_to_do exp %0d got %0d", want.wtd, got.wtd);
          end
        end
      end
      pending <= clip_q.size();
    end
  end

endmodule

// ===== test/tb_video_rect_clip_and_scale.sv =====
// Testbench top for video_rect_clip_and_scale: drives clip requests and register
// writes with random idling and gives the verdict. Depends on vrc_pkg and vrc_clip_checker.
module tb_video_rect_clip_and_scale;
  import vrc_pkg::*;

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [183:0] s_tdata;
  logic [127:0] m_tdata;
  logic cfg_we;
  cfg_idx_t cfg_index;
  size_t cfg_data;
  int errors, pending, cycles, stall_left;
  bit quiet;
  size_t lim[4];

  video_rect_clip_and_scale u_top (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  vrc_clip_checker u_chk (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: after every result word, unless quiet is set, hold off for a random number of cycles.
  always @(posedge clk) begin
    int n;
    n = stall_left;
    if (rst) n = 0;
    else if (m_tvalid && m_tready) n = quiet ? 0 : $urandom_range(0, 6);
    else if (n > 0) n = n - 1;
    stall_left <= n;
    m_tready <= !rst && n == 0;
  end

  function automatic logic [183:0] pack_req(int sx, int sy, int sw, int sh, int dx, int dy,
                                            int dw, int dh, int osw, int osh, int odw, int odh);
    logic [15:0] c[4];
    logic [14:0] z[8];
    c = '{sx[15:0], sy[15:0], dx[15:0], dy[15:0]};
    z = '{sw[14:0], sh[14:0], dw[14:0], dh[14:0], osw[14:0], osh[14:0], odw[14:0], odh[14:0]};
    return {z[7], z[6], z[5], z[4], z[3], z[2], c[3], c[2], z[1], z[0], c[1], c[0]};
  endfunction

  // Presents one request and returns at the edge where it is taken.
  task automatic send_req(logic [183:0] d);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= d;
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    @(posedge clk);
  endtask

  task automatic set_limits(int a, int b, int c, int d);
    lim = '{a[14:0], b[14:0], c[14:0], d[14:0]};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data <= lim[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic int pick_size(int m);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, 32767);
    if (r == 1) return 0;
    r = $urandom_range(1, m + 64);
    return r > 32767 ? 32767 : r;
  endfunction

  function automatic int pick_term(int sz);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r < 4) return sz;
    return $urandom_range(1, 32767);
  endfunction

  task automatic random_req();
    int sw, sh, dw, dh, sx, sy, dx, dy;
    if ($urandom_range(0, 9) == 0) begin
      send_req(184'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
      return;
    end
    sw = pick_size(lim[0]); sh = pick_size(lim[1]);
    dw = ($urandom_range(0, 3) == 0) ? sw : pick_size(lim[2]);
    dh = ($urandom_range(0, 3) == 0) ? sh : pick_size(lim[3]);
    sx = $urandom_range(0, lim[0]) - $urandom_range(0, sw / 2 + 1);
    sy = $urandom_range(0, lim[1]) - $urandom_range(0, sh / 2 + 1);
    dx = $urandom_range(0, lim[2]) - $urandom_range(0, dw / 2 + 1);
    dy = $urandom_range(0, lim[3]) - $urandom_range(0, dh / 2 + 1);
    send_req(pack_req(sx, sy, sw, sh, dx, dy, dw, dh,
                      pick_term(sw), pick_term(sh), pick_term(dw), pick_term(dh)));
  endtask

  initial begin
    int counts[7];
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_we = 0;
    cfg_index = CFG_MAX_SRC_W;
    cfg_data = '0;
    quiet = 0;
    lim = '{SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX};
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes, trims on every edge, empty result, equal sizes,
    // zero ratio terms, zero sizes and origin wrap.
    send_req('0);
    send_req('1);
    send_req(pack_req(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
                      32767, 32767, 32767, 32767));
    send_req(pack_req(32767, 32767, 1, 1, 32767, 32767, 1, 1, 1, 1, 1, 1));
    send_req(pack_req(10, 20, 100, 50, 30, 40, 200, 100, 100, 50, 200, 100));
    send_req(pack_req(-10, 0, 100, 50, 0, 0, 200, 50, 100, 50, 200, 50));
    send_req(pack_req(0, -10, 100, 50, 0, 0, 100, 80, 100, 50, 100, 80));
    send_req(pack_req(0, 0, 100, 50, -20, -5, 200, 100, 100, 50, 200, 100));
    send_req(pack_req(32700, 0, 100, 50, 0, 0, 300, 50, 100, 50, 300, 50));
    send_req(pack_req(0, 0, 100, 50, 32700, 32760, 300, 40, 100, 50, 300, 40));
    send_req(pack_req(-100, 0, 50, 50, 0, 0, 60, 50, 50, 50, 60, 50));
    send_req(pack_req(0, -100, 50, 50, 0, 0, 50, 60, 50, 50, 50, 60));
    send_req(pack_req(-10, -10, 100, 100, 0, 0, 100, 100, 1, 1, 1, 1));
    send_req(pack_req(-10, 0, 100, 100, 5, 0, 300, 100, 0, 0, 0, 0));
    send_req(pack_req(0, 0, 100, 100, -10, 0, 300, 100, 100, 100, 0, 100));
    send_req(pack_req(0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 1));
    send_req(pack_req(-1, 0, 0, 5, 0, 0, 5, 5, 5, 5, 5, 5));
    send_req(pack_req(-32768, 0, 32767, 10, 32767, 0, 32767, 10, 1, 1, 32767, 1));
    send_req(pack_req(-1000, 0, 5000, 10, 32000, 0, 700, 10, 1, 1, 32767, 1));
    send_req(pack_req(-5, -5, 20, 20, -30, -30, 30000, 30000, 20, 20, 30000, 30000));
    drain();

    counts = '{300, 300, 300, 60, 350, 350, 300};
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: ;
        1: set_limits($urandom_range(50, 2000), $urandom_range(50, 2000),
                      $urandom_range(50, 2000), $urandom_range(50, 2000));
        2: set_limits(1, 32767, 32767, 1);
        3: set_limits(0, 0, 0, 0);
        4: set_limits($urandom_range(1, 32767), $urandom_range(1, 32767),
                      $urandom_range(1, 32767), $urandom_range(1, 32767));
        5: set_limits(32767, 1, 1, 32767);
        default: set_limits(32767, 32767, 32767, 32767);
      endcase
      quiet = (ph == 2 || ph == 5);
      for (int i = 0; i < counts[ph]; i++) random_req();
      drain();
    end

    quiet = 0;
    repeat (100) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/vrc_pkg.sv
sv/vrc_delay.sv
sv/vrc_trim.sv
sv/vrc_axis.sv
sv/video_rect_clip_and_scale.sv
sv/vrc_checker.sv
test/vrc_clip_checker.sv
test/tb_video_rect_clip_and_scale.sv
